// File: design/glf_pkg.sv
`default_nettype none

package glf_pkg;

  // grid size defaults
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0]  REG_ACTIVE_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_ACTIVE_COLS = 1'd1;
  localparam logic [CFG_DATA_W-1:0] ACTIVE_RESET    = 7'd64;

  // beat widths
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;

  // b3/s23 neighbour counts
  localparam logic [3:0] SURVIVE_LO = 4'd2;
  localparam logic [3:0] BIRTH_CNT  = 4'd3;

  // operation codes carried in tuser
  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_TOGGLE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_STEP   = 2'd3
  } mode_t;

endpackage

`default_nettype wire

// File: design/glf_row_cell.sv
`default_nettype none

// one row word of the grid, shifting along the ring when enabled
module glf_row_cell #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             shift_en,
  input  wire logic [WIDTH-1:0] row_in,
  output logic      [WIDTH-1:0] row_out
);

  logic [WIDTH-1:0] row_r;

  // row storage, dead after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (shift_en) begin
      row_r <= row_in;
    end
  end

  assign row_out = row_r;

endmodule

`default_nettype wire

// File: design/glf_row_rule.sv
`default_nettype none

// next generation of one row from its upper, own and lower neighbours
module glf_row_rule #(
  parameter int NCOLS = 64
) (
  input  wire logic [NCOLS-1:0] row_above,
  input  wire logic [NCOLS-1:0] row_self,
  input  wire logic [NCOLS-1:0] row_below,
  output logic      [NCOLS-1:0] row_new
);

  import glf_pkg::*;

  logic [NCOLS+1:0] pad_a;
  logic [NCOLS+1:0] pad_s;
  logic [NCOLS+1:0] pad_b;

  // dead border on both sides, no wrap
  assign pad_a = {1'b0, row_above, 1'b0};
  assign pad_s = {1'b0, row_self, 1'b0};
  assign pad_b = {1'b0, row_below, 1'b0};

  for (genvar c = 0; c < NCOLS; c++) begin : g_col
    logic [3:0] nbr_cnt;

    // eight-neighbour count
    assign nbr_cnt = 4'(pad_a[c]) + 4'(pad_a[c+1]) + 4'(pad_a[c+2])
                   + 4'(pad_s[c]) + 4'(pad_s[c+2])
                   + 4'(pad_b[c]) + 4'(pad_b[c+1]) + 4'(pad_b[c+2]);

    // survive on two or three, born on three
    assign row_new[c] = row_self[c] ? (nbr_cnt == SURVIVE_LO || nbr_cnt == BIRTH_CNT)
                                    : (nbr_cnt == BIRTH_CNT);
  end

endmodule

`default_nettype wire

// File: design/life_automaton_grid_top.sv
`default_nettype none

// Life grid with rule B3/S23. The grid is a ring of MAX_ROWS row registers,
// each MAX_COLS cells wide, all dead after reset. Every beat on the input
// side (write, toggle, read or one generation step) drives the ring through
// one full turn of MAX_ROWS shifts: the row at the head of the ring passes
// through the rule logic or the cell access logic and re-enters at the tail,
// one row word per cycle. After the turn the result passes through the wait
// state into the output register, and the input is ready again only once the
// result has moved there, so the block takes no new item before that.
// A new item is accepted while the previous result is still waiting; a result
// that is still waiting when the next turn ends holds the block until it is
// taken. active_rows and active_cols limit the area in use; cells outside it
// keep their values and count as dead.
module life_automaton_grid_top #(
  parameter int MAX_ROWS = glf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = glf_pkg::DEF_MAX_COLS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration writes
  input  wire logic                             cfg_we,
  input  wire logic [glf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [glf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input beats
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // row_index[5:0], col_index[11:6], write_value[12], zero[15:13]
  input  wire logic [glf_pkg::IN_DATA_W-1:0]    in_tdata,
  // mode[1:0]
  input  wire logic [glf_pkg::IN_USER_W-1:0]    in_tuser,
  // result beats
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // cell_value[0], addr_ok[1], zero[7:2]
  output logic      [glf_pkg::OUT_DATA_W-1:0]   out_tdata
);

  import glf_pkg::*;

  localparam int RIX  = $clog2(MAX_ROWS);
  localparam int CIX  = $clog2(MAX_COLS);
  localparam int RSW  = $clog2(MAX_ROWS + 1);
  localparam int CSW  = $clog2(MAX_COLS + 1);
  localparam int CW0  = (RSW > CFG_DATA_W) ? RSW : CFG_DATA_W;
  localparam int CW   = (CSW > CW0) ? CSW : CW0;
  localparam int CXW  = (CIX > 6) ? CIX : 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_t;

  state_t                state_r;
  logic [RIX-1:0]        cnt_r;
  mode_t                 op_mode_r;
  logic [5:0]            op_row_r;
  logic [5:0]            op_col_r;
  logic                  op_wv_r;
  logic                  acc_ok_r;
  logic                  res_cell_r;
  logic                  res_ok_r;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [MAX_COLS-1:0]   prev_r;

  logic [CFG_DATA_W-1:0] active_rows_r;
  logic [CFG_DATA_W-1:0] active_cols_r;

  logic [MAX_COLS-1:0]   row_q  [MAX_ROWS];
  logic [MAX_COLS-1:0]   row_d  [MAX_ROWS];

  logic [CW-1:0]         used_rows;
  logic [CW-1:0]         used_cols;
  logic [CW-1:0]         ar_ext;
  logic [CW-1:0]         ac_ext;
  logic [CW-1:0]         cnt_ext;
  logic [MAX_COLS-1:0]   col_mask;
  logic                  in_acc;
  mode_t                 in_mode;
  logic [5:0]            in_row;
  logic [5:0]            in_col;
  logic                  in_range;
  logic                  shift_en;
  logic                  row_live;
  logic                  end_row;
  logic                  hit;
  logic                  out_load;
  logic [CXW-1:0]        col_w;
  logic [CIX-1:0]        col_sel;
  logic [MAX_COLS-1:0]   col_bit;
  logic [MAX_COLS-1:0]   head;
  logic [MAX_COLS-1:0]   rule_above;
  logic [MAX_COLS-1:0]   rule_self;
  logic [MAX_COLS-1:0]   rule_below;
  logic [MAX_COLS-1:0]   rule_new;
  logic [MAX_COLS-1:0]   gen_word;
  logic [MAX_COLS-1:0]   acc_word;
  logic [MAX_COLS-1:0]   tail_in;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_rows_r <= ACTIVE_RESET;
      active_cols_r <= ACTIVE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_ACTIVE_ROWS) begin
        active_rows_r <= cfg_wdata;
      end else if (cfg_index == REG_ACTIVE_COLS) begin
        active_cols_r <= cfg_wdata;
      end
    end
  end

  // active size, clipped to the grid
  assign ar_ext    = CW'(active_rows_r);
  assign ac_ext    = CW'(active_cols_r);
  assign used_rows = (ar_ext > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : ar_ext;
  assign used_cols = (ac_ext > CW'(MAX_COLS)) ? CW'(MAX_COLS) : ac_ext;

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
    assign col_mask[c] = (CW'(c) < used_cols);
  end

  // input beat fields
  assign in_mode  = mode_t'(in_tuser);
  assign in_row   = in_tdata[5:0];
  assign in_col   = in_tdata[11:6];
  assign in_range = (CW'(in_row) < used_rows) && (CW'(in_col) < used_cols);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // ring of row cells, head at index zero
  assign shift_en = (state_r == ST_RUN);

  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_ring
    if (i == MAX_ROWS - 1) begin : g_tail
      assign row_d[i] = tail_in;
    end else begin : g_link
      assign row_d[i] = row_q[i+1];
    end

    glf_row_cell #(
      .WIDTH (MAX_COLS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .row_in   (row_d[i]),
      .row_out  (row_q[i])
    );
  end

  // head row position within the active area
  assign head     = row_q[0];
  assign cnt_ext  = CW'(cnt_r);
  assign row_live = (cnt_ext < used_rows);
  assign end_row  = ((cnt_ext + CW'(1)) == used_rows);

  // neighbour rows, dead outside the active area
  assign rule_above = (cnt_r == '0) ? '0 : (prev_r & col_mask);
  assign rule_self  = head & col_mask;
  assign rule_below = end_row ? '0 : (row_q[1] & col_mask);

  glf_row_rule #(
    .NCOLS (MAX_COLS)
  ) u_rule (
    .row_above (rule_above),
    .row_self  (rule_self),
    .row_below (rule_below),
    .row_new   (rule_new)
  );

  // generation result, inactive columns and rows untouched
  assign gen_word = row_live ? ((rule_new & col_mask) | (head & ~col_mask)) : head;

  // single cell access on the addressed row
  assign col_w   = CXW'(op_col_r);
  assign col_sel = col_w[CIX-1:0];
  assign col_bit = {{(MAX_COLS-1){1'b0}}, 1'b1} << col_sel;
  assign hit     = acc_ok_r && (cnt_ext == CW'(op_row_r));

  always_comb begin
    unique case (op_mode_r)
      MODE_WRITE:  acc_word = op_wv_r ? (head | col_bit) : (head & ~col_bit);
      MODE_TOGGLE: acc_word = head ^ col_bit;
      default:     acc_word = head;
    endcase
  end

  assign tail_in = (op_mode_r == MODE_STEP) ? gen_word : (hit ? acc_word : head);

  // finished result moves into the output register once it is free
  assign out_load = (state_r == ST_WAIT) && (!out_tvalid_r || out_tready);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_data_r   <= {{(OUT_DATA_W-2){1'b0}}, res_ok_r, res_cell_r};
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r    <= ST_RUN;
            cnt_r      <= '0;
            op_mode_r  <= in_mode;
            op_row_r   <= in_row;
            op_col_r   <= in_col;
            op_wv_r    <= in_tdata[12];
            acc_ok_r   <= in_range && (in_mode != MODE_STEP);
            res_cell_r <= 1'b0;
            res_ok_r   <= in_range || (in_mode == MODE_STEP);
          end
        end
        ST_RUN: begin
          prev_r <= head;
          if (hit) begin
            res_cell_r <= |(acc_word & col_bit);
          end
          if (cnt_r == RIX'(MAX_ROWS - 1)) begin
            state_r <= ST_WAIT;
          end else begin
            cnt_r <= cnt_r + RIX'(1);
          end
        end
        ST_WAIT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // an accepted beat starts a ring turn from the head
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_RUN) && (cnt_r == '0))
    else $error("ring turn did not start at row zero");

  // a full turn ends after the last row
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (cnt_r == RIX'(MAX_ROWS - 1)) |=> (state_r == ST_WAIT))
    else $error("ring turn did not end after the last row");

  // generation step reports dead cell with address good
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) && (op_mode_r == MODE_STEP) |-> res_ok_r && !res_cell_r)
    else $error("generation step result malformed");

  // rejected access reports nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) && !res_ok_r |-> !res_cell_r && !acc_ok_r)
    else $error("out of range access produced a cell value");

endmodule

`default_nettype wire
